// ===== rtl/core/text_command_led_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Text command LED controller: assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_COMMAND_LED_CONTROLLER_DEFINES_SVH
`define TEXT_COMMAND_LED_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define TCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Text command LED controller package
// Sizes, command texts, reply texts and shared types.
// ----------------------------------------------------------------------------
package tcl_pkg;

	localparam int LINE_DEPTH = 16;
	localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
	localparam int NUM_CMDS   = 6;
	localparam int CMD_MAX    = 5;
	localparam int PRE_DEPTH  = CMD_MAX + 1;
	localparam int PRE_W      = $clog2(PRE_DEPTH);
	localparam int MSG_IDX_W  = 4;
	localparam int LONG_LEN   = 16;
	localparam int BAD_LEN    = 12;

	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [7:0] CMD_TXT [NUM_CMDS][PRE_DEPTH] = '{
		'{"L", "R", "O", "N", 8'h00, 8'h00},
		'{"L", "R", "O", "F", "F",  8'h00},
		'{"L", "G", "O", "N", 8'h00, 8'h00},
		'{"L", "G", "O", "F", "F",  8'h00},
		'{"L", "B", "O", "N", 8'h00, 8'h00},
		'{"L", "B", "O", "F", "F",  8'h00}
	};
	localparam int CMD_LEN [NUM_CMDS] = '{4, 5, 4, 5, 4, 5};
	localparam logic [1:0] CMD_LAMP [NUM_CMDS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
	localparam logic CMD_SET [NUM_CMDS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

	localparam logic [7:0] TXT_LONG [16] = '{
		"Z", "b", "y", "t", " ", "d", "l", "u", "g", "i", " ", "c", "i", "a", "g", CHAR_LF
	};
	localparam logic [7:0] TXT_BAD [16] = '{
		"Z", "l", "a", " ", "k", "o", "m", "e", "n", "d", "a", CHAR_LF,
		8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [1:0] {
		JOB_NONE = 2'd0,
		JOB_ACK  = 2'd1,
		JOB_LONG = 2'd2,
		JOB_BAD  = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [2:0] lamps;
	} job_t;

	function automatic logic [7:0] msg_char(job_kind_t kind, logic [MSG_IDX_W-1:0] idx);
		logic [7:0] ch;
		if (kind == JOB_LONG) begin
			ch = TXT_LONG[idx];
		end else begin
			ch = TXT_BAD[idx];
		end
		return ch;
	endfunction

	function automatic logic [MSG_IDX_W-1:0] msg_last(job_kind_t kind);
		logic [MSG_IDX_W-1:0] li;
		if (kind == JOB_LONG) begin
			li = MSG_IDX_W'(LONG_LEN - 1);
		end else begin
			li = MSG_IDX_W'(BAD_LEN - 1);
		end
		return li;
	endfunction

endpackage

// ===== rtl/core/tcl_line_decoder.sv =====
// ----------------------------------------------------------------------------
// Line decoder
// Collects line bytes, tracks overflow and lamps, classifies a line on LF.
// ----------------------------------------------------------------------------
module tcl_line_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      rx_byte_s1,
	input  logic            take,
	output tcl_pkg::job_t   job
);

	logic [tcl_pkg::FILL_W-1:0] fill_q;
	logic                       ovf_q;
	logic [2:0]                 lamp_q;
	logic [7:0]                 pre_q [tcl_pkg::PRE_DEPTH];
	logic [tcl_pkg::NUM_CMDS-1:0] hit;
	logic [2:0]                 lamps_n;
	logic                       is_lf;

	assign is_lf = (rx_byte_s1 == tcl_pkg::CHAR_LF);

	// only the first bytes of a line can decide a match; later ones just count
	always_comb begin
		hit = '0;
		for (int c = 0; c < tcl_pkg::NUM_CMDS; c++) begin
			hit[c] = 1'b1;
			for (int j = 0; j < tcl_pkg::CMD_MAX; j++) begin
				if (j < tcl_pkg::CMD_LEN[c]) begin
					if (!(fill_q > tcl_pkg::FILL_W'(j) &&
					      pre_q[j] == tcl_pkg::CMD_TXT[c][j])) begin
						hit[c] = 1'b0;
					end
				end
			end
			if (fill_q > tcl_pkg::FILL_W'(tcl_pkg::CMD_LEN[c]) &&
			    pre_q[tcl_pkg::CMD_LEN[c]] != 8'h00) begin
				hit[c] = 1'b0;
			end
		end
	end

	always_comb begin
		lamps_n = lamp_q;
		for (int c = 0; c < tcl_pkg::NUM_CMDS; c++) begin
			if (hit[c]) begin
				lamps_n[tcl_pkg::CMD_LAMP[c]] = tcl_pkg::CMD_SET[c];
			end
		end
	end

	always_comb begin
		job.lamps = lamp_q;
		if (!is_lf) begin
			job.kind = tcl_pkg::JOB_NONE;
		end else if (ovf_q) begin
			job.kind = tcl_pkg::JOB_LONG;
		end else if (|hit) begin
			job.kind  = tcl_pkg::JOB_ACK;
			job.lamps = lamps_n;
		end else begin
			job.kind = tcl_pkg::JOB_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			lamp_q <= '0;
		end else if (take) begin
			if (!is_lf) begin
				if (!ovf_q && fill_q < tcl_pkg::FILL_W'(tcl_pkg::LINE_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == tcl_pkg::FILL_W'(tcl_pkg::LINE_DEPTH - 1)) begin
						ovf_q <= 1'b1;
					end
				end
			end else begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
				lamp_q <= job.lamps;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !is_lf && !ovf_q && fill_q < tcl_pkg::FILL_W'(tcl_pkg::PRE_DEPTH)) begin
			pre_q[fill_q[tcl_pkg::PRE_W-1:0]] <= rx_byte_s1;
		end
	end

endmodule

// ===== rtl/core/tcl_reply_seq.sv =====
// ----------------------------------------------------------------------------
// Reply sequencer
// Result register; streams reply texts one character per transaction.
// ----------------------------------------------------------------------------
module tcl_reply_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tcl_pkg::job_t job,
	output logic          rdy,
	output logic          res_valid,
	input  logic          res_stall,
	output logic          tx_valid,
	output logic [7:0]    tx_char,
	output logic          red_on,
	output logic          green_on,
	output logic          blue_on,
	output logic          last
);

	logic                            out_valid_q;
	logic                            busy_q;
	tcl_pkg::job_kind_t              kind_q;
	logic [tcl_pkg::MSG_IDX_W-1:0]   idx_q;
	logic [2:0]                      lamps_q;
	logic                            tx_valid_q;
	logic [7:0]                      tx_char_q;
	logic [2:0]                      out_lamps_q;
	logic                            last_q;
	logic                            out_free;
	logic                            at_end;

	assign out_free = !out_valid_q || !res_stall;
	assign rdy      = !busy_q && out_free;
	assign at_end   = (idx_q == tcl_pkg::msg_last(kind_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
		end else if (out_free) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				if (at_end) begin
					busy_q <= 1'b0;
				end
			end else if (start) begin
				out_valid_q <= 1'b1;
				busy_q      <= (job.kind != tcl_pkg::JOB_ACK);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (busy_q) begin
				tx_valid_q  <= 1'b1;
				tx_char_q   <= tcl_pkg::msg_char(kind_q, idx_q);
				out_lamps_q <= lamps_q;
				last_q      <= at_end;
				idx_q       <= idx_q + 1'b1;
			end else if (start) begin
				kind_q      <= job.kind;
				lamps_q     <= job.lamps;
				out_lamps_q <= job.lamps;
				idx_q       <= tcl_pkg::MSG_IDX_W'(1);
				if (job.kind == tcl_pkg::JOB_ACK) begin
					tx_valid_q <= 1'b0;
					tx_char_q  <= 8'h00;
					last_q     <= 1'b1;
				end else begin
					tx_valid_q <= 1'b1;
					tx_char_q  <= tcl_pkg::msg_char(job.kind, '0);
					last_q     <= 1'b0;
				end
			end
		end
	end

	assign res_valid = out_valid_q;
	assign tx_valid  = tx_valid_q;
	assign tx_char   = tx_char_q;
	assign red_on    = out_lamps_q[0];
	assign green_on  = out_lamps_q[1];
	assign blue_on   = out_lamps_q[2];
	assign last      = last_q;

endmodule

// ===== rtl/core/text_command_led_controller.sv =====
// ----------------------------------------------------------------------------
// Text command LED controller
// Ordinary bytes are accepted one per cycle, unless a waiting line feed
// holds the input, and produce no result. A line feed produces one result
// for a lamp command (LRON, LROFF, LGON, LGOFF, LBON, LBOFF), 12 results for
// "Zla komenda" plus LF, or 16 results for "Zbyt dlugi ciag" plus LF when the
// line reached 16 bytes. Replies leave the result register one character per
// cycle while res_stall is low; ordinary bytes keep flowing while the reply
// sequencer is busy, and the next line feed waits for the sequencer.
// ----------------------------------------------------------------------------
module text_command_led_controller (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       tx_valid,
	output logic [7:0] tx_char,
	output logic       red_on,
	output logic       green_on,
	output logic       blue_on,
	output logic       last
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          adv;
	logic          seq_rdy;
	tcl_pkg::job_t job;

	assign adv      = valid_s1 && (job.kind == tcl_pkg::JOB_NONE || seq_rdy);
	assign rx_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || adv) && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	tcl_line_decoder u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte_s1 (byte_s1),
		.take       (adv),
		.job        (job)
	);

	tcl_reply_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (adv && job.kind != tcl_pkg::JOB_NONE),
		.job       (job),
		.rdy       (seq_rdy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.tx_valid  (tx_valid),
		.tx_char   (tx_char),
		.red_on    (red_on),
		.green_on  (green_on),
		.blue_on   (blue_on),
		.last      (last)
	);

endmodule

// ===== rtl/core/tcl_checker.sv =====
// ----------------------------------------------------------------------------
// Text command LED controller checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_command_led_controller_defines.svh"

module tcl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic       tx_valid,
	input logic [7:0] tx_char,
	input logic       red_on,
	input logic       green_on,
	input logic       blue_on,
	input logic       last
);

	logic [12:0] res_bits;

	assign res_bits = {tx_valid, tx_char, red_on, green_on, blue_on, last};

	`TCL_ASSERT_NOW(a_ack_single, res_valid && !tx_valid, last && tx_char == 8'h00, "ack not single")
	`TCL_ASSERT_NOW(a_reply_ends_lf, res_valid && tx_valid && last, tx_char == 8'h0A, "no LF at end")
	`TCL_ASSERT_NOW(a_no_early_lf, res_valid && tx_valid && !last, tx_char != 8'h0A, "LF in reply")
	`TCL_ASSERT_NEXT(a_no_gap, res_valid && !res_stall && !last, res_valid && tx_valid, "reply gap")
	`TCL_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(res_bits), "result moved")

endmodule

bind text_command_led_controller tcl_checker u_chk (.*);
